@@ rtl/core/gcd_pkg.sv @@
// Package with the shared constants, types and codes of the glyph contour decoder.
`timescale 1ns / 1ps
`default_nettype none

package gcd_pkg;

  localparam int MAX_CMD_BYTES = 255;

  // Command store address width and the width of the command counters.
  localparam int ADDR_W = (MAX_CMD_BYTES > 1) ? $clog2(MAX_CMD_BYTES) : 1;
  localparam int CMD_W  = $clog2(4 * MAX_CMD_BYTES + 1);

  // A header count at or above this value needs more command bytes than the store holds.
  localparam logic [14:0] CNT_LIMIT = 15'(4 * MAX_CMD_BYTES);

  localparam int COORD_N = 6;

  localparam logic [7:0] HDR_NOT_CONTOUR = 8'h80;
  localparam logic [7:0] HDR_EXT_COUNT   = 8'b0100_0000;
  localparam logic [7:0] HDR_COUNT_MASK  = 8'b0011_1111;
  localparam logic [7:0] CMD_MASK        = 8'b0000_0011;

  localparam logic [1:0] ST_SEGMENT     = 2'd0;
  localparam logic [1:0] ST_BAD_OFFSET  = 2'd1;
  localparam logic [1:0] ST_NOT_CONTOUR = 2'd2;
  localparam logic [1:0] ST_TOO_MANY    = 2'd3;

  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_QUAD  = 2'd2;
  localparam logic [1:0] KIND_CUBIC = 2'd3;

  localparam logic REG_FRAG_START = 1'b0;
  localparam logic REG_CHAR_START = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_EXT,
    PH_CMDS,
    PH_COORD
  } phase_e;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] seg_kind;
    logic [8:0] end_x;
    logic [8:0] end_y;
    logic [8:0] ctl1_x;
    logic [8:0] ctl1_y;
    logic [8:0] ctl2_x;
    logic [8:0] ctl2_y;
    logic       last_seg;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/gcd_if.sv @@
// Stream interfaces for the input bytes and the decoded segments.
`timescale 1ns / 1ps
`default_nettype none

interface gcd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [31:0] frag_offset;
  logic [7:0]  origin_x;
  logic [7:0]  origin_y;

  modport source (
    output valid, data_byte, first_byte, frag_offset, origin_x, origin_y,
    input  ready
  );
  modport sink (
    input  valid, data_byte, first_byte, frag_offset, origin_x, origin_y,
    output ready
  );
endinterface

interface gcd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] seg_kind;
  logic [8:0] end_x;
  logic [8:0] end_y;
  logic [8:0] ctl1_x;
  logic [8:0] ctl1_y;
  logic [8:0] ctl2_x;
  logic [8:0] ctl2_y;
  logic       last_seg;

  modport source (
    output valid, status, seg_kind, end_x, end_y, ctl1_x, ctl1_y, ctl2_x, ctl2_y,
           last_seg,
    input  ready
  );
  modport sink (
    input  valid, status, seg_kind, end_x, end_y, ctl1_x, ctl1_y, ctl2_x, ctl2_y,
           last_seg,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/gcd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module gcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/glyph_contour_decoder.sv @@
// Top level of the glyph contour decoder: header parse, command store and segment build.
//
//   Channel   Dir   Handshake      Content
//   in_i      in    valid/ready    one fragment byte, header marker, offset, origin
//   out_o     out   valid/ready    one segment or error status per transfer
//   cfg_*     in    write enable   fragment and character table bounds
//
// A new byte is taken each cycle while the result register is empty or being drained.
// The command byte for the current command is read from the command store ahead of its
// use, with a bypass when it was written in the cycle before. Reset clears control
// state only; the command store is never cleared. A stalled result holds the input off
// until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module glyph_contour_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  gcd_in_if.sink           in_i,
  gcd_out_if.source        out_o
);

  localparam int AW = gcd_pkg::ADDR_W;
  localparam int CW = gcd_pkg::CMD_W;

  gcd_pkg::phase_e  phase_q, phase_d;
  logic [31:0]      frag_start_q, char_start_q;
  logic [CW-1:0]    cmd_total_q, cmd_total_d;
  logic [CW-1:0]    cmd_index_q, cmd_index_d;
  logic [5:0]       ext_hi_q, ext_hi_d;
  logic [2:0]       coord_cnt_q, coord_cnt_d;
  logic [7:0]       coord_buf_q [gcd_pkg::COORD_N];
  logic [7:0]       coord_buf_d [gcd_pkg::COORD_N];
  logic [7:0]       base_x_q, base_x_d, base_y_q, base_y_d;
  logic             out_valid_q, out_valid_d;
  gcd_pkg::result_t res_q, res_d;
  logic             fwd_q, fwd_d;
  logic [7:0]       fwd_data_q;

  logic             fire_in;
  logic             emit;
  logic [7:0]       data;
  logic             off_bad;
  logic [13:0]      cnt;
  logic             count_bad;
  logic [14:0]      cnt_inc;
  logic [CW-1:0]    total_new;
  logic [CW:0]      bytes_need;
  logic [CW:0]      cmd_inc;
  logic             cmds_done;
  logic [7:0]       ram_rdata;
  logic [7:0]       cmd_byte;
  logic [1:0]       kind;
  logic [2:0]       need;
  logic [2:0]       cc_inc;
  logic             seg_done;
  logic             seg_last;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire_in    = in_i.valid && in_i.ready;
  assign data       = in_i.data_byte;

  assign off_bad   = (in_i.frag_offset < frag_start_q) || (in_i.frag_offset >= char_start_q);
  assign cnt       = (phase_q == gcd_pkg::PH_EXT && !in_i.first_byte) ? {ext_hi_q, data}
                   : {8'd0, data[5:0]};
  assign count_bad = {1'b0, cnt} >= gcd_pkg::CNT_LIMIT;
  assign cnt_inc   = {1'b0, cnt} + 15'd1;
  assign total_new = CW'(cnt_inc);

  assign bytes_need = ({1'b0, cmd_total_q} + (CW+1)'(3)) >> 2;
  assign cmd_inc    = {1'b0, cmd_index_q} + (CW+1)'(1);
  assign cmds_done  = cmd_inc >= bytes_need;

  assign cmd_byte = fwd_q ? fwd_data_q : ram_rdata;

  always_comb begin
    case (cmd_index_q[1:0])
      2'd0:    kind = cmd_byte[1:0] & gcd_pkg::CMD_MASK[1:0];
      2'd1:    kind = cmd_byte[3:2] & gcd_pkg::CMD_MASK[1:0];
      2'd2:    kind = cmd_byte[5:4] & gcd_pkg::CMD_MASK[1:0];
      default: kind = cmd_byte[7:6] & gcd_pkg::CMD_MASK[1:0];
    endcase
  end

  assign need     = (kind == gcd_pkg::KIND_CUBIC) ? 3'd6
                  : (kind == gcd_pkg::KIND_QUAD) ? 3'd4 : 3'd2;
  assign cc_inc   = coord_cnt_q + 3'd1;
  assign seg_done = cc_inc >= need;
  assign seg_last = cmd_inc >= {1'b0, cmd_total_q};

  always_comb begin
    phase_d = phase_q;
    if (fire_in) begin
      if (in_i.first_byte) begin
        if (off_bad || (data & gcd_pkg::HDR_NOT_CONTOUR) != 8'd0) begin
          phase_d = gcd_pkg::PH_IDLE;
        end else if ((data & gcd_pkg::HDR_EXT_COUNT) != 8'd0) begin
          phase_d = gcd_pkg::PH_EXT;
        end else if (count_bad) begin
          phase_d = gcd_pkg::PH_IDLE;
        end else begin
          phase_d = gcd_pkg::PH_CMDS;
        end
      end else begin
        case (phase_q)
          gcd_pkg::PH_EXT: begin
            phase_d = count_bad ? gcd_pkg::PH_IDLE : gcd_pkg::PH_CMDS;
          end
          gcd_pkg::PH_CMDS: begin
            phase_d = cmds_done ? gcd_pkg::PH_COORD : gcd_pkg::PH_CMDS;
          end
          gcd_pkg::PH_COORD: begin
            phase_d = (seg_done && seg_last) ? gcd_pkg::PH_IDLE : gcd_pkg::PH_COORD;
          end
          default: begin
            phase_d = gcd_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    cmd_total_d = cmd_total_q;
    cmd_index_d = cmd_index_q;
    ext_hi_d    = ext_hi_q;
    coord_cnt_d = coord_cnt_q;
    coord_buf_d = coord_buf_q;
    base_x_d    = base_x_q;
    base_y_d    = base_y_q;
    ram_we      = 1'b0;
    ram_waddr   = cmd_index_q[AW-1:0];
    emit        = 1'b0;
    res_d       = res_q;
    if (fire_in) begin
      res_d          = '0;
      res_d.last_seg = 1'b1;
      if (in_i.first_byte) begin
        base_x_d    = in_i.origin_x;
        base_y_d    = in_i.origin_y;
        cmd_index_d = '0;
        coord_cnt_d = '0;
        if (off_bad) begin
          emit         = 1'b1;
          res_d.status = gcd_pkg::ST_BAD_OFFSET;
        end else if ((data & gcd_pkg::HDR_NOT_CONTOUR) != 8'd0) begin
          emit         = 1'b1;
          res_d.status = gcd_pkg::ST_NOT_CONTOUR;
        end else if ((data & gcd_pkg::HDR_EXT_COUNT) != 8'd0) begin
          ext_hi_d = 6'(data & gcd_pkg::HDR_COUNT_MASK);
        end else if (count_bad) begin
          emit         = 1'b1;
          res_d.status = gcd_pkg::ST_TOO_MANY;
        end else begin
          cmd_total_d = total_new;
        end
      end else begin
        case (phase_q)
          gcd_pkg::PH_EXT: begin
            if (count_bad) begin
              emit         = 1'b1;
              res_d.status = gcd_pkg::ST_TOO_MANY;
            end else begin
              cmd_total_d = total_new;
              cmd_index_d = '0;
            end
          end
          gcd_pkg::PH_CMDS: begin
            ram_we      = 1'b1;
            coord_cnt_d = '0;
            cmd_index_d = cmds_done ? '0 : CW'(cmd_inc);
          end
          gcd_pkg::PH_COORD: begin
            if (coord_cnt_q < 3'(gcd_pkg::COORD_N)) begin
              coord_buf_d[coord_cnt_q] = data;
            end
            if (seg_done) begin
              emit           = 1'b1;
              coord_cnt_d    = '0;
              cmd_index_d    = CW'(cmd_inc);
              res_d.status   = gcd_pkg::ST_SEGMENT;
              res_d.seg_kind = kind;
              res_d.last_seg = seg_last;
              res_d.end_x    = {1'b0, base_x_q} + {1'b0, coord_buf_d[0]};
              res_d.end_y    = {1'b0, base_y_q} + {1'b0, coord_buf_d[1]};
              if (kind == gcd_pkg::KIND_QUAD || kind == gcd_pkg::KIND_CUBIC) begin
                res_d.ctl1_x = {1'b0, base_x_q} + {1'b0, coord_buf_d[2]};
                res_d.ctl1_y = {1'b0, base_y_q} + {1'b0, coord_buf_d[3]};
              end
              if (kind == gcd_pkg::KIND_CUBIC) begin
                res_d.ctl2_x = {1'b0, base_x_q} + {1'b0, coord_buf_d[4]};
                res_d.ctl2_y = {1'b0, base_y_q} + {1'b0, coord_buf_d[5]};
              end
            end else begin
              coord_cnt_d = cc_inc;
            end
          end
          default: begin
            res_d = res_q;
          end
        endcase
      end
      if (!emit) begin
        res_d = res_q;
      end
    end
  end

  assign out_valid_d = fire_in ? (emit || (out_valid_q && !out_o.ready))
                     : (out_valid_q && !out_o.ready);

  assign ram_raddr = cmd_index_d[AW+1:2];
  assign fwd_d     = ram_we && (ram_waddr == ram_raddr);

  gcd_ram #(
    .Width (8),
    .Depth (gcd_pkg::MAX_CMD_BYTES)
  ) u_cmd_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= gcd_pkg::PH_IDLE;
      frag_start_q <= '0;
      char_start_q <= '0;
      cmd_total_q  <= '0;
      cmd_index_q  <= '0;
      ext_hi_q     <= '0;
      coord_cnt_q  <= '0;
      base_x_q     <= '0;
      base_y_q     <= '0;
      out_valid_q  <= 1'b0;
      fwd_q        <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_total_q <= cmd_total_d;
      cmd_index_q <= cmd_index_d;
      ext_hi_q    <= ext_hi_d;
      coord_cnt_q <= coord_cnt_d;
      base_x_q    <= base_x_d;
      base_y_q    <= base_y_d;
      out_valid_q <= out_valid_d;
      fwd_q       <= fwd_d;
      if (cfg_we_i && cfg_idx_i == gcd_pkg::REG_FRAG_START) begin
        frag_start_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == gcd_pkg::REG_CHAR_START) begin
        char_start_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    coord_buf_q <= coord_buf_d;
    res_q       <= res_d;
    fwd_data_q  <= data;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = res_q.status;
  assign out_o.seg_kind = res_q.seg_kind;
  assign out_o.end_x    = res_q.end_x;
  assign out_o.end_y    = res_q.end_y;
  assign out_o.ctl1_x   = res_q.ctl1_x;
  assign out_o.ctl1_y   = res_q.ctl1_y;
  assign out_o.ctl2_x   = res_q.ctl2_x;
  assign out_o.ctl2_y   = res_q.ctl2_y;
  assign out_o.last_seg = res_q.last_seg;

endmodule

`default_nettype wire

@@ sim/tb_glyph_contour_decoder.sv @@
// Self-checking testbench for the glyph contour decoder: directed and random fragment streams.
`timescale 1ns / 1ps

module tb_glyph_contour_decoder;
  import gcd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic [31:0] offset;
    logic [7:0]  org_x;
    logic [7:0]  org_y;
  } frag_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  gcd_in_if  in_if ();
  gcd_out_if out_if ();

  glyph_contour_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Decoder state mirrored by the testbench.
  logic [31:0]  bound_lo;
  logic [31:0]  bound_hi;
  phase_e       frag_phase;
  int unsigned  cmd_total;
  int unsigned  cmd_idx;
  logic [7:0]   cmd_store [MAX_CMD_BYTES];
  logic [7:0]   coord_buf [COORD_N];
  int unsigned  coord_cnt;
  logic [7:0]   base_x;
  logic [7:0]   base_y;

  result_t      seg_expected [$];

  int unsigned  src_idle_pct;
  int unsigned  sink_stall_pct;
  int unsigned  fault_count;
  int unsigned  bytes_sent;
  int unsigned  frags_sent;
  int unsigned  results_checked;
  int unsigned  error_results;
  int unsigned  bound_settings;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_glyph_contour_decoder: errors");
    $finish;
  end

  function automatic bit reject(input logic [1:0] code, output result_t seg);
    seg          = '0;
    seg.status   = code;
    seg.last_seg = 1'b1;
    frag_phase   = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit take_count(input int unsigned count, output result_t seg);
    seg       = '0;
    cmd_total = count + 1;
    if ((cmd_total + 3) / 4 > MAX_CMD_BYTES) begin
      return reject(ST_TOO_MANY, seg);
    end
    cmd_idx    = 0;
    frag_phase = PH_CMDS;
    return 1'b0;
  endfunction

  // Advances the mirrored state by one byte; returns 1 when a result is due.
  function automatic bit decode_byte(input frag_byte_t b, output result_t seg);
    logic [1:0]  kind;
    int unsigned need;
    seg = '0;
    if (b.first) begin
      base_x    = b.org_x;
      base_y    = b.org_y;
      cmd_idx   = 0;
      coord_cnt = 0;
      if (b.offset < bound_lo || b.offset >= bound_hi) begin
        return reject(ST_BAD_OFFSET, seg);
      end
      if ((b.data & HDR_NOT_CONTOUR) != 0) begin
        return reject(ST_NOT_CONTOUR, seg);
      end
      if ((b.data & HDR_EXT_COUNT) != 0) begin
        cmd_total  = b.data & HDR_COUNT_MASK;
        frag_phase = PH_EXT;
        return 1'b0;
      end
      return take_count(b.data & HDR_COUNT_MASK, seg);
    end
    case (frag_phase)
      PH_EXT: begin
        return take_count(((cmd_total & 32'h3F) << 8) | b.data, seg);
      end
      PH_CMDS: begin
        if (cmd_idx < MAX_CMD_BYTES) begin
          cmd_store[cmd_idx] = b.data;
        end
        cmd_idx++;
        if (cmd_idx >= (cmd_total + 3) / 4) begin
          cmd_idx    = 0;
          coord_cnt  = 0;
          frag_phase = PH_COORD;
        end
        return 1'b0;
      end
      PH_COORD: begin
        kind = 2'((cmd_store[cmd_idx >> 2] >> ((cmd_idx & 3) * 2)) & CMD_MASK);
        need = (kind == KIND_CUBIC) ? 6 : (kind == KIND_QUAD) ? 4 : 2;
        if (coord_cnt < COORD_N) begin
          coord_buf[coord_cnt] = b.data;
        end
        coord_cnt++;
        if (coord_cnt < need) begin
          return 1'b0;
        end
        seg.status   = ST_SEGMENT;
        seg.seg_kind = kind;
        seg.end_x    = 9'(base_x) + 9'(coord_buf[0]);
        seg.end_y    = 9'(base_y) + 9'(coord_buf[1]);
        if (kind == KIND_QUAD || kind == KIND_CUBIC) begin
          seg.ctl1_x = 9'(base_x) + 9'(coord_buf[2]);
          seg.ctl1_y = 9'(base_y) + 9'(coord_buf[3]);
        end
        if (kind == KIND_CUBIC) begin
          seg.ctl2_x = 9'(base_x) + 9'(coord_buf[4]);
          seg.ctl2_y = 9'(base_y) + 9'(coord_buf[5]);
        end
        coord_cnt = 0;
        cmd_idx++;
        seg.last_seg = (cmd_idx >= cmd_total);
        if (seg.last_seg) begin
          frag_phase = PH_IDLE;
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  function automatic string fmt_seg(input result_t s);
    return $sformatf("st=%0d kind=%0d end=(%0d,%0d) c1=(%0d,%0d) c2=(%0d,%0d) last=%0d",
                     s.status, s.seg_kind, s.end_x, s.end_y, s.ctl1_x, s.ctl1_y,
                     s.ctl2_x, s.ctl2_y, s.last_seg);
  endfunction

  task automatic check_segment();
    result_t got;
    result_t want;
    string   diff;
    got.status   = out_if.status;
    got.seg_kind = out_if.seg_kind;
    got.end_x    = out_if.end_x;
    got.end_y    = out_if.end_y;
    got.ctl1_x   = out_if.ctl1_x;
    got.ctl1_y   = out_if.ctl1_y;
    got.ctl2_x   = out_if.ctl2_x;
    got.ctl2_y   = out_if.ctl2_y;
    got.last_seg = out_if.last_seg;
    results_checked++;
    if (got.status != ST_SEGMENT) begin
      error_results++;
    end
    if (seg_expected.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: result with none expected: %s", $realtime, fmt_seg(got));
      end
      return;
    end
    want = seg_expected.pop_front();
    diff = "";
    if (got.status !== want.status)     diff = {diff, " status"};
    if (got.seg_kind !== want.seg_kind) diff = {diff, " seg_kind"};
    if (got.end_x !== want.end_x)       diff = {diff, " end_x"};
    if (got.end_y !== want.end_y)       diff = {diff, " end_y"};
    if (got.ctl1_x !== want.ctl1_x)     diff = {diff, " ctl1_x"};
    if (got.ctl1_y !== want.ctl1_y)     diff = {diff, " ctl1_y"};
    if (got.ctl2_x !== want.ctl2_x)     diff = {diff, " ctl2_x"};
    if (got.ctl2_y !== want.ctl2_y)     diff = {diff, " ctl2_y"};
    if (got.last_seg !== want.last_seg) diff = {diff, " last_seg"};
    if (diff != "") begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("%0t: mismatch in%s", $realtime, diff);
        $display("  expected %s", fmt_seg(want));
        $display("  actual   %s", fmt_seg(got));
      end
    end
  endtask

  // Result side: checks each transfer and stalls at random.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      check_segment();
    end
    out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [7:0] pick_origin();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [31:0] pick_offset(input bit good);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned rnd;
    lo  = bound_lo;
    hi  = bound_hi;
    rnd = {$urandom, $urandom};
    if (good && hi > lo) begin
      return 32'(lo + rnd % (hi - lo));
    end
    if (lo > 0 && $urandom_range(1) == 0) begin
      return 32'(rnd % lo);
    end
    return 32'(hi + rnd % (64'h1_0000_0000 - hi));
  endfunction

  function automatic frag_byte_t head_byte(input logic [7:0] data, input logic [31:0] off,
                                           input logic [7:0] ox, input logic [7:0] oy);
    frag_byte_t b;
    b.data   = data;
    b.first  = 1'b1;
    b.offset = off;
    b.org_x  = ox;
    b.org_y  = oy;
    return b;
  endfunction

  function automatic frag_byte_t body_byte(input logic [7:0] data);
    frag_byte_t b;
    b.data   = data;
    b.first  = 1'b0;
    b.offset = $urandom;
    b.org_x  = 8'($urandom);
    b.org_y  = 8'($urandom);
    return b;
  endfunction

  // Moves one byte across the input channel and records the result it is due to cause.
  task automatic send_byte(input frag_byte_t b, input bit counted = 1'b1);
    result_t seg;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b.data;
    in_if.first_byte  <= b.first;
    in_if.frag_offset <= b.offset;
    in_if.origin_x    <= b.org_x;
    in_if.origin_y    <= b.org_y;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (decode_byte(b, seg)) begin
      seg_expected.push_back(seg);
    end
    if (counted) bytes_sent++;
    if (b.first) frags_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (seg_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_bounds(input logic [31:0] lo, input logic [31:0] hi);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAG_START;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= REG_CHAR_START;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
    bound_settings++;
  endtask

  // Sends one contour fragment with random commands and coordinates, cut short on request.
  task automatic send_contour(input int unsigned count, input bit ext, input bit light,
                              input bit truncate);
    frag_byte_t  q [$];
    logic [7:0]  cmds [$];
    logic [7:0]  c;
    logic [1:0]  kind;
    logic [31:0] off;
    logic [7:0]  ox;
    logic [7:0]  oy;
    int unsigned n;
    int unsigned nb;
    int unsigned need;
    int unsigned cut;
    off = pick_offset(1'b1);
    ox  = pick_origin();
    oy  = pick_origin();
    if (ext) begin
      q.push_back(head_byte(HDR_EXT_COUNT | 8'(count >> 8), off, ox, oy));
      q.push_back(body_byte(8'(count)));
    end else begin
      q.push_back(head_byte(8'(count) & HDR_COUNT_MASK, off, ox, oy));
    end
    n  = count + 1;
    nb = (n + 3) / 4;
    for (int i = 0; i < nb; i++) begin
      c = 8'($urandom);
      if (light && i != nb - 1) c = c & 8'h55;
      cmds.push_back(c);
      q.push_back(body_byte(c));
    end
    for (int k = 0; k < n; k++) begin
      kind = 2'((cmds[k >> 2] >> ((k & 3) * 2)) & CMD_MASK);
      need = (kind == KIND_CUBIC) ? 6 : (kind == KIND_QUAD) ? 4 : 2;
      repeat (need) q.push_back(body_byte(8'($urandom)));
    end
    cut = truncate ? $urandom_range(1, q.size() - 1) : q.size();
    for (int i = 0; i < cut; i++) begin
      send_byte(q[i]);
    end
  endtask

  task automatic send_random_fragment();
    int unsigned r;
    int unsigned count;
    logic [5:0]  hi6;
    r = $urandom_range(99);
    if (r < 8) begin
      send_byte(head_byte(8'($urandom), pick_offset(1'b0), pick_origin(), pick_origin()));
    end else if (r < 13) begin
      send_byte(head_byte(HDR_NOT_CONTOUR | 8'($urandom), pick_offset(1'b1),
                          pick_origin(), pick_origin()));
    end else if (r < 18) begin
      hi6 = 6'($urandom_range(3, 63));
      send_byte(head_byte(HDR_EXT_COUNT | 8'(hi6), pick_offset(1'b1),
                          pick_origin(), pick_origin()));
      send_byte(body_byte((hi6 == 6'd3) ? 8'($urandom_range(8'hFC, 8'hFF)) : 8'($urandom)));
    end else if (r < 26) begin
      send_contour($urandom_range(0, 7), $urandom_range(1), 1'b0, 1'b1);
    end else begin
      if (r < 32 && frag_phase == PH_IDLE) begin
        repeat ($urandom_range(1, 3)) send_byte(body_byte(8'($urandom)), 1'b0);
      end
      r = $urandom_range(99);
      if (r < 65) begin
        send_contour($urandom_range(0, 7), 1'b0, 1'b0, 1'b0);
      end else if (r < 80) begin
        send_contour($urandom_range(8, 31), 1'b0, 1'b0, 1'b0);
      end else if (r < 88) begin
        send_contour($urandom_range(32, 63), 1'b0, 1'b0, 1'b0);
      end else begin
        count = $urandom_range(0, 47);
        send_contour(count, 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic test_random(input int unsigned n_bytes);
    int unsigned stop;
    stop = bytes_sent + n_bytes;
    while (bytes_sent < stop) begin
      send_random_fragment();
    end
  endtask

  task automatic test_directed();
    write_bounds(32'h0000_0000, 32'hFFFF_FFFF);
    // All four segment kinds, the first three at the largest sums and the cubic closing the fragment.
    send_byte(head_byte(8'h03, 32'h0000_0000, 8'hFF, 8'hFF));
    send_byte(body_byte(8'hE4));
    repeat (8) send_byte(body_byte(8'hFF));
    for (int i = 0; i < 6; i++) begin
      send_byte(body_byte((i % 2 == 0) ? 8'h00 : 8'hFF));
    end
    // A stray byte while idle is dropped.
    send_byte(body_byte(8'h5A));
    send_byte(head_byte(8'h00, 32'hFFFF_FFFF, 8'h00, 8'h00));
    send_byte(head_byte(8'hC5, 32'hFFFF_FFFE, 8'h07, 8'h09));
    // Extended count of 1020, that is 1021 commands, needs one command byte too many.
    send_byte(head_byte(8'h43, 32'h0000_0001, 8'h10, 8'h20));
    send_byte(body_byte(8'hFC));
    // An extended-count fragment abandoned by a new fragment before its command byte.
    send_byte(head_byte(8'h40, 32'h0000_0002, 8'h01, 8'h02));
    send_byte(body_byte(8'h00));
    send_byte(head_byte(8'h00, 32'h0000_0003, 8'h00, 8'h00));
    send_byte(body_byte(8'h01));
    send_byte(body_byte(8'h00));
    send_byte(body_byte(8'h00));
  endtask

  // Largest accepted count: every entry of the command store is written, and the
  // fragment is left after its first few segments.
  task automatic test_full_store();
    int unsigned count;
    count = 4 * MAX_CMD_BYTES - 1;
    send_byte(head_byte(HDR_EXT_COUNT | 8'(count >> 8), 32'h0000_0010, 8'h80, 8'h7F));
    send_byte(body_byte(8'(count)));
    for (int i = 0; i < MAX_CMD_BYTES; i++) begin
      send_byte(body_byte(8'($urandom) & 8'h55));
    end
    repeat (12) send_byte(body_byte(8'($urandom)));
  endtask

  task automatic test_idle_mode(input int unsigned mode);
    logic [31:0] a;
    logic [31:0] b;
    case (mode)
      0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
      1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
      default: begin src_idle_pct = 12; sink_stall_pct = 12; end
    endcase
    a = $urandom;
    b = $urandom;
    case (mode)
      0: write_bounds(32'h0000_0000, 32'h0000_0000);
      1: write_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      2: write_bounds((a > b) ? a : b + 1, (a > b) ? b : a);
      default: write_bounds(a, a);
    endcase
    test_random(1);
    a = $urandom;
    b = $urandom;
    case (mode)
      0: write_bounds(32'h0000_0000, 32'hFFFF_FFFF);
      1: write_bounds(a & 32'hFFFF_FFFE, (a & 32'hFFFF_FFFE) + 1);
      2: write_bounds((a < b) ? a : b, ((a < b) ? b : a) | 32'h1);
      default: write_bounds(32'h0000_0000, a | 32'h8000_0000);
    endcase
    test_random(20);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= REG_FRAG_START;
    cfg_wdata_i       <= '0;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.first_byte  <= 1'b0;
    in_if.frag_offset <= '0;
    in_if.origin_x    <= '0;
    in_if.origin_y    <= '0;
    bound_lo          = '0;
    bound_hi          = '0;
    frag_phase        = PH_IDLE;
    cmd_total         = 0;
    cmd_idx           = 0;
    coord_cnt         = 0;
    base_x            = '0;
    base_y            = '0;
    foreach (coord_buf[i]) coord_buf[i] = '0;
    src_idle_pct      = 0;
    sink_stall_pct    = 0;
    fault_count       = 0;
    bytes_sent        = 0;
    frags_sent        = 0;
    results_checked   = 0;
    error_results     = 0;
    bound_settings    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();
    for (int m = 0; m < 4; m++) begin
      test_idle_mode(m);
    end
    wait_drained();

    $display("Sent %0d bytes in %0d fragments; checked %0d results, %0d of them errors.",
             bytes_sent, frags_sent, results_checked, error_results);
    $display("Covered four idle and stall modes, %0d table bound settings and a full store.",
             bound_settings);
    if (fault_count == 0) begin
      $display("tb_glyph_contour_decoder: clean");
    end else begin
      $display("tb_glyph_contour_decoder: errors");
    end
    $finish;
  end

endmodule

@@ glyph_contour_decoder.f @@
rtl/core/gcd_pkg.sv
rtl/core/gcd_if.sv
rtl/core/gcd_ram.sv
rtl/core/glyph_contour_decoder.sv
sim/tb_glyph_contour_decoder.sv
